// ===== rtl/pcg_pkg.sv =====
// ----------------------------------------------------------------------------
// pcg_pkg
// Shared types, constants and the output permutation of the PCG32 core.
// ----------------------------------------------------------------------------
package pcg_pkg;

  localparam int unsigned STATE_W  = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STREAM_W = 63;

  // LCG multiplier, split into 32-bit halves for the shared multiplier
  localparam logic [DATA_W-1:0] MULT_LO = 32'h4C95_7F2D;
  localparam logic [DATA_W-1:0] MULT_HI = 32'h5851_F42D;

  typedef enum logic [1:0] {
    REQ_RESEED  = 2'd0,
    REQ_NEXT    = 2'd1,
    REQ_BOUNDED = 2'd2,
    REQ_UNUSED  = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_MUL0,
    ST_MUL1,
    ST_MUL2,
    ST_MUL3,
    ST_ADD_SEED,
    ST_LIMIT,
    ST_LIMIT_WAIT,
    ST_CHECK,
    ST_MOD_WAIT,
    ST_OUT
  } ctrl_state_t;

  // Phases of the 64-bit modular multiply-add
  typedef enum logic [2:0] {
    MS_NONE,
    MS_P0,
    MS_P1,
    MS_P2,
    MS_P3
  } mul_step_t;

  typedef enum logic {
    DIV_LIMIT,
    DIV_DRAW
  } div_sel_t;

  typedef struct packed {
    logic      capture;
    logic      reseed_load;
    logic      draw;
    mul_step_t mul_step;
    logic      add_seed;
    logic      div_start;
    div_sel_t  div_sel;
    logic      limit_load;
    logic      out_load;
    logic      out_raw;
  } pcg_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic bound_zero;
    logic draw_ge_limit;
    logic out_free;
  } pcg_sts_t;

  // XSH-RR output: xorshift high bits, then rotate right by the top 5 bits
  function automatic logic [DATA_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
    logic [STATE_W-1:0]  x;
    logic [DATA_W-1:0]   mixed;
    logic [4:0]          rot;
    logic [2*DATA_W-1:0] dbl;
    x     = (old >> 18) ^ old;
    mixed = x[58:27];
    rot   = old[63:59];
    dbl   = {mixed, mixed} >> rot;
    return dbl[DATA_W-1:0];
  endfunction

endpackage

// ===== rtl/pcg_if.sv =====
// ----------------------------------------------------------------------------
// pcg_if
// Valid/ready channels of the PCG32 core: request and result.
// ----------------------------------------------------------------------------
interface pcg_req_if import pcg_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [STATE_W-1:0]  seed_value;
  logic [STREAM_W-1:0] stream_select;
  logic [DATA_W-1:0]   upper_bound;

  modport source (output valid, req_type, seed_value, stream_select, upper_bound,
                  input ready);
  modport sink   (input valid, req_type, seed_value, stream_select, upper_bound,
                  output ready);
endinterface

interface pcg_rsp_if import pcg_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] random_value;

  modport source (output valid, random_value, input ready);
  modport sink   (input valid, random_value, output ready);
endinterface

// ===== rtl/pcg_div.sv =====
// ----------------------------------------------------------------------------
// pcg_div
// Radix-2 restoring divider, remainder only, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pcg_div import pcg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              busy,
  output logic [DATA_W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(DATA_W + 1);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] num_r, num_nxt;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    trial    = {rem_r, num_r[DATA_W-1]};
    diff     = trial - {1'b0, divisor};
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DATA_W);
      rem_nxt  = '0;
      num_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt  = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];
      num_nxt  = {num_r[DATA_W-2:0], 1'b0};
      cnt_nxt  = cnt_r - CNT_W'(1);
      busy_nxt = (cnt_r != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    num_r <= num_nxt;
  end

  assign busy      = busy_r;
  assign remainder = rem_r;

endmodule

// ===== rtl/pcg_dp.sv =====
// ----------------------------------------------------------------------------
// pcg_dp
// Datapath: LCG state and increment, shared 32x32 multiplier, draw and
// limit registers, divider and the result register.
// ----------------------------------------------------------------------------
module pcg_dp import pcg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  pcg_cmd_t            cmd,
  output pcg_sts_t            sts,
  input  logic [STATE_W-1:0]  in_seed_value,
  input  logic [STREAM_W-1:0] in_stream_select,
  input  logic [DATA_W-1:0]   in_upper_bound,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DATA_W-1:0]   out_random_value
);

  logic [STATE_W-1:0] state_r, state_nxt;
  logic [STATE_W-1:0] inc_r, inc_nxt;
  logic [STATE_W-1:0] acc_r, acc_nxt;
  logic [STATE_W-1:0] prod_r;
  logic [STATE_W-1:0] seed_r;
  logic [DATA_W-1:0]  bound_r;
  logic [DATA_W-1:0]  draw_r;
  logic [DATA_W-1:0]  limit_r;
  logic [DATA_W-1:0]  res_r;
  logic               out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]  mul_a, mul_b;
  logic [STATE_W-1:0] prod_hi_sh;
  logic [DATA_W-1:0]  div_dividend;
  logic               div_busy;
  logic [DATA_W-1:0]  div_rem;
  logic               out_free;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = state_r[DATA_W-1:0];
    mul_b = MULT_LO;
    unique case (cmd.mul_step)
      MS_P1:   mul_a = state_r[STATE_W-1:DATA_W];
      MS_P2:   mul_b = MULT_HI;
      default: ;
    endcase
  end

  assign prod_hi_sh = {prod_r[DATA_W-1:0], {DATA_W{1'b0}}};

  // state update: reseed, seed add and the multiply-add phases
  always_comb begin
    state_nxt = state_r;
    inc_nxt   = inc_r;
    acc_nxt   = acc_r;
    if (cmd.reseed_load) begin
      state_nxt = '0;
      inc_nxt   = {in_stream_select, 1'b1};
    end
    if (cmd.add_seed) begin
      state_nxt = state_r + seed_r;
    end
    unique case (cmd.mul_step)
      MS_P1:   acc_nxt   = prod_r + inc_r;
      MS_P2:   acc_nxt   = acc_r + prod_hi_sh;
      MS_P3:   state_nxt = acc_r + prod_hi_sh;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      inc_r       <= STATE_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inc_r       <= inc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    acc_r  <= acc_nxt;
    prod_r <= {{DATA_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};
    if (cmd.capture) begin
      seed_r  <= in_seed_value;
      bound_r <= in_upper_bound;
    end
    if (cmd.draw) begin
      draw_r <= xsh_rr(state_r);
    end
    if (cmd.limit_load) begin
      limit_r <= div_rem;
    end
    if (cmd.out_load) begin
      res_r <= cmd.out_raw ? draw_r : div_rem;
    end
  end

  // threshold is (2^32 - bound) mod bound; the final value is draw mod bound
  assign div_dividend = (cmd.div_sel == DIV_LIMIT) ? (DATA_W'(0) - bound_r) : draw_r;

  pcg_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_dividend),
    .divisor   (bound_r),
    .busy      (div_busy),
    .remainder (div_rem)
  );

  // result register; the next request may run while it waits
  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign sts.div_busy      = div_busy;
  assign sts.bound_zero    = (bound_r == '0);
  assign sts.draw_ge_limit = (draw_r >= limit_r);
  assign sts.out_free      = out_free;

  assign out_valid        = out_valid_r;
  assign out_random_value = res_r;

  // checks
  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result register overwritten before transfer");

  a_inc_odd: assert property (@(posedge clk) disable iff (!rst_n)
    inc_r[0])
    else $error("LCG increment is even");

  a_state_hold_div: assert property (@(posedge clk) disable iff (!rst_n)
    (div_busy && $past(div_busy)) |-> $stable(state_r))
    else $error("state changed during a division");

endmodule

// ===== rtl/pcg_ctrl.sv =====
// ----------------------------------------------------------------------------
// pcg_ctrl
// Controller: sequences reseed, draw, multiply-add, rejection and modulo.
// ----------------------------------------------------------------------------
module pcg_ctrl import pcg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  req_type_t in_req_type,
  input  pcg_sts_t  sts,
  output pcg_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;
  req_type_t   kind_r, kind_nxt;
  logic        pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= REQ_UNUSED;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    pass_nxt    = pass_r;
    cmd         = '0;
    cmd.out_raw = (kind_r == REQ_NEXT) || sts.bound_zero;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          kind_nxt    = in_req_type;
          pass_nxt    = 1'b0;
          unique case (in_req_type)
            REQ_RESEED: begin
              cmd.reseed_load = 1'b1;
              state_nxt       = ST_MUL0;
            end
            REQ_NEXT:    state_nxt = ST_DRAW;
            REQ_BOUNDED: state_nxt = ST_LIMIT;
            default:     state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DRAW: begin
        cmd.draw  = 1'b1;
        state_nxt = ST_MUL0;
      end
      ST_MUL0: begin
        cmd.mul_step = MS_P0;
        state_nxt    = ST_MUL1;
      end
      ST_MUL1: begin
        cmd.mul_step = MS_P1;
        state_nxt    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul_step = MS_P2;
        state_nxt    = ST_MUL3;
      end
      ST_MUL3: begin
        cmd.mul_step = MS_P3;
        priority if (kind_r == REQ_RESEED) begin
          state_nxt = pass_r ? ST_IDLE : ST_ADD_SEED;
        end else if (kind_r == REQ_NEXT || sts.bound_zero) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_ADD_SEED: begin
        cmd.add_seed = 1'b1;
        pass_nxt     = 1'b1;
        state_nxt    = ST_MUL0;
      end
      ST_LIMIT: begin
        if (sts.bound_zero) begin
          state_nxt = ST_DRAW;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_LIMIT;
          state_nxt     = ST_LIMIT_WAIT;
        end
      end
      ST_LIMIT_WAIT: begin
        if (!sts.div_busy) begin
          cmd.limit_load = 1'b1;
          state_nxt      = ST_DRAW;
        end
      end
      // reject draws below the threshold
      ST_CHECK: begin
        if (sts.draw_ge_limit) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = DIV_DRAW;
          state_nxt     = ST_MOD_WAIT;
        end else begin
          state_nxt = ST_DRAW;
        end
      end
      ST_MOD_WAIT: begin
        if (!sts.div_busy) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/pcg32_random_generator_core.sv =====
// ----------------------------------------------------------------------------
// pcg32_random_generator_core
// PCG32 XSH-RR random number generator with reseed, raw and bounded draws.
//
// Requests are taken one at a time. A raw draw does one state update, a
// reseed two with the seed added between. Each 64-bit update is four phases
// of a single shared 32x32 multiplier. A bounded draw adds two passes of
// the 32-step radix-2 divider (threshold and final modulo); every rejected
// draw repeats the draw and update. Bound 0 returns the raw draw. Request
// code 3 is dropped with no effect. A finished result sits in an output
// register, so the next request is accepted while it waits for transfer.
// ----------------------------------------------------------------------------
module pcg32_random_generator_core import pcg_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  pcg_req_if.sink   in_chan,
  pcg_rsp_if.source out_chan
);

  pcg_cmd_t cmd;
  pcg_sts_t sts;

  pcg_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_chan.valid),
    .in_ready    (in_chan.ready),
    .in_req_type (req_type_t'(in_chan.req_type)),
    .sts         (sts),
    .cmd         (cmd)
  );

  pcg_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_seed_value    (in_chan.seed_value),
    .in_stream_select (in_chan.stream_select),
    .in_upper_bound   (in_chan.upper_bound),
    .out_valid        (out_chan.valid),
    .out_ready        (out_chan.ready),
    .out_random_value (out_chan.random_value)
  );

endmodule

// ===== tb/sv/pcg32_draw_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcg32_draw_checker
// Watches the request and result channels of the PCG32 core. It keeps its own
// copy of the LCG state and increment, works out the value that each accepted
// request must return, and compares every result transfer against the oldest
// outstanding value.
// ----------------------------------------------------------------------------
module pcg32_draw_checker import pcg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  input  logic                req_ready,
  input  logic [1:0]          req_type,
  input  logic [STATE_W-1:0]  req_seed,
  input  logic [STREAM_W-1:0] req_stream,
  input  logic [DATA_W-1:0]   req_bound,
  input  logic                rsp_valid,
  input  logic                rsp_ready,
  input  logic [DATA_W-1:0]   rsp_value,
  output int unsigned         fail_count,
  output int unsigned         words_pending
);

  localparam logic [STATE_W-1:0] LCG_MULTIPLIER = 64'd6364136223846793005;

  logic [STATE_W-1:0] gen_state;
  logic [STATE_W-1:0] gen_incr;
  logic [DATA_W-1:0]  expected_words[$];

  // One generator step: permute the old state, then advance the LCG
  function automatic logic [DATA_W-1:0] step_generator();
    logic [STATE_W-1:0] prev;
    logic [STATE_W-1:0] folded;
    logic [DATA_W-1:0]  mixed;
    logic [5:0]         rot;
    prev      = gen_state;
    gen_state = prev * LCG_MULTIPLIER + gen_incr;
    folded    = prev ^ (prev >> 18);
    mixed     = DATA_W'(folded >> 27);
    rot       = {1'b0, prev[63:59]};
    if (rot == 6'd0) begin
      return mixed;
    end
    return (mixed >> rot) | (mixed << (6'd32 - rot));
  endfunction

  // Unbiased value below the bound by rejection; zero bound gives a raw word
  function automatic logic [DATA_W-1:0] bounded_word(input logic [DATA_W-1:0] bound);
    logic [DATA_W-1:0] neg_bound;
    logic [DATA_W-1:0] threshold;
    logic [DATA_W-1:0] word;
    if (bound == '0) begin
      return step_generator();
    end
    neg_bound = '0 - bound;
    threshold = neg_bound % bound;
    word      = step_generator();
    while (word < threshold) begin
      word = step_generator();
    end
    return word % bound;
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $time, what);
    fail_count++;
  endtask

  assign words_pending = expected_words.size();

  // Result check first: a result never belongs to a request of the same edge
  always @(posedge clk) begin
    if (!rst_n) begin
      gen_state  = '0;
      gen_incr   = 64'd1;
      fail_count = 0;
      expected_words.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("unexpected result random_value=%08h", rsp_value));
        end else begin
          logic [DATA_W-1:0] want;
          want = expected_words.pop_front();
          if (rsp_value !== want) begin
            report_mismatch($sformatf("random_value got %08h want %08h", rsp_value, want));
          end
        end
      end
      if (req_valid && req_ready) begin
        case (req_type_t'(req_type))
          REQ_RESEED: begin
            gen_state = '0;
            gen_incr  = {req_stream, 1'b1};
            void'(step_generator());
            gen_state = gen_state + req_seed;
            void'(step_generator());
          end
          REQ_NEXT:    expected_words.push_back(step_generator());
          REQ_BOUNDED: expected_words.push_back(bounded_word(req_bound));
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/sv/tb_pcg32_random_generator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pcg32_random_generator_core
// Stimulus and verdict for the PCG32 core. A directed burst covers the field
// extremes, every request kind, zero and extreme bounds and the unused code;
// random traffic follows in four phases of sender and receiver idling. The
// checker beside the core does all prediction and comparison.
// ----------------------------------------------------------------------------
module tb_pcg32_random_generator_core;
  import pcg_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned DRAIN_CYCLES = 200;

  logic        clk;
  logic        rst_n;
  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned fail_count;
  int unsigned words_pending;
  int unsigned sent;

  pcg_req_if in_if ();
  pcg_rsp_if out_if ();

  pcg32_random_generator_core u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  pcg32_draw_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (in_if.valid),
    .req_ready     (in_if.ready),
    .req_type      (in_if.req_type),
    .req_seed      (in_if.seed_value),
    .req_stream    (in_if.stream_select),
    .req_bound     (in_if.upper_bound),
    .rsp_valid     (out_if.valid),
    .rsp_ready     (out_if.ready),
    .rsp_value     (out_if.random_value),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
  end

  always #6 clk = ~clk;

  // Receiver: ready changes at the falling edge, stalling at the phase rate
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // One request transfer; entered and left at a falling edge
  task automatic send_req(input req_type_t kind, input logic [STATE_W-1:0] seed,
                          input logic [STREAM_W-1:0] stream,
                          input logic [DATA_W-1:0] bound);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.req_type      <= kind;
    in_if.seed_value    <= seed;
    in_if.stream_select <= stream;
    in_if.upper_bound   <= bound;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_bound();
    case ($urandom_range(0, 5))
      0: return $urandom_range(1, 16);
      1: return $urandom;
      2: return 32'd1 << $urandom_range(0, 31);
      3: return 32'h8000_0000 + $urandom_range(0, 255);
      4: return '0;
      default: return 32'hFFFF_FFFF - $urandom_range(0, 15);
    endcase
  endfunction

  // Mostly draws, some reseeds; unused codes are sent but not counted
  task automatic send_random();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 8) begin
      send_req(REQ_RESEED, {$urandom, $urandom}, STREAM_W'({$urandom, $urandom}),
               $urandom);
      sent++;
    end else if (pick < 11) begin
      send_req(REQ_UNUSED, {$urandom, $urandom}, STREAM_W'({$urandom, $urandom}),
               $urandom);
    end else if (pick < 50) begin
      send_req(REQ_NEXT, {$urandom, $urandom}, STREAM_W'({$urandom, $urandom}),
               $urandom);
      sent++;
    end else begin
      send_req(REQ_BOUNDED, {$urandom, $urandom}, STREAM_W'({$urandom, $urandom}),
               pick_bound());
      sent++;
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    tx_idle_pct         = 0;
    rx_stall_pct        = 0;
    sent                = 0;
    in_if.valid         = 1'b0;
    in_if.req_type      = REQ_NEXT;
    in_if.seed_value    = '0;
    in_if.stream_select = '0;
    in_if.upper_bound   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: draws from the reset state, bound extremes, reseed extremes
    send_req(REQ_NEXT, '0, '0, '0);
    send_req(REQ_NEXT, '1, '1, '1);
    send_req(REQ_BOUNDED, '0, '0, 32'd0);
    send_req(REQ_BOUNDED, '0, '0, 32'd1);
    send_req(REQ_BOUNDED, '0, '0, 32'd2);
    send_req(REQ_BOUNDED, '0, '0, 32'hFFFF_FFFF);
    send_req(REQ_BOUNDED, '0, '0, 32'h8000_0001);
    send_req(REQ_BOUNDED, '0, '0, 32'h8000_0000);
    send_req(REQ_RESEED, '0, '0, '0);
    send_req(REQ_NEXT, '0, '0, '0);
    send_req(REQ_RESEED, '1, '1, '1);
    send_req(REQ_NEXT, '0, '0, '0);
    send_req(REQ_BOUNDED, '0, '0, 32'd3);
    send_req(REQ_UNUSED, '1, '1, '1);
    send_req(REQ_NEXT, '0, '0, '0);
    send_req(REQ_RESEED, 64'h8000_0000_0000_0000, 63'h4000_0000_0000_0000, '0);
    send_req(REQ_BOUNDED, '0, '0, 32'd7);
    send_req(REQ_BOUNDED, '1, '1, 32'd0);
    send_req(REQ_UNUSED, {$urandom, $urandom}, STREAM_W'({$urandom, $urandom}), $urandom);
    send_req(REQ_NEXT, '0, '0, '0);
    send_req(REQ_RESEED, {$urandom, $urandom}, STREAM_W'({$urandom, $urandom}), $urandom);
    send_req(REQ_BOUNDED, '0, '0, 32'd6);
    send_req(REQ_NEXT, '0, '0, '0);

    // Random traffic in four idling phases
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 68; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 68; end
        default: begin tx_idle_pct = 13; rx_stall_pct = 13; end
      endcase
      sent = 0;
      while (sent < RANDOM_ITEMS / 4) begin
        send_random();
      end
    end
    in_if.valid <= 1'b0;

    // Drain outstanding results, then let any trailing request finish
    while (words_pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== pcg32_random_generator_core.f =====
rtl/pcg_pkg.sv
rtl/pcg_if.sv
rtl/pcg_div.sv
rtl/pcg_dp.sv
rtl/pcg_ctrl.sv
rtl/pcg32_random_generator_core.sv
tb/sv/pcg32_draw_checker.sv
tb/sv/tb_pcg32_random_generator_core.sv
